// ===== sv/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// shared types, codes and defaults of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_LEN_DEF = 12;
  localparam int HIST_LEN_DEF = 64;

  typedef logic [7:0] byte_t;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  localparam logic [1:0] EV_DONE   = 2'd0;
  localparam logic [1:0] EV_CANCEL = 2'd1;
  localparam logic [1:0] EV_EOF    = 2'd2;

  localparam logic CFG_IGN_ESC  = 1'b0;
  localparam logic CFG_IGN_LEAD = 1'b1;

  localparam byte_t CH_NUL = 8'h00;
  localparam byte_t CH_SOH = 8'h01;
  localparam byte_t CH_STX = 8'h02;
  localparam byte_t CH_ETX = 8'h03;
  localparam byte_t CH_EOT = 8'h04;
  localparam byte_t CH_ENQ = 8'h05;
  localparam byte_t CH_ACK = 8'h06;
  localparam byte_t CH_BS  = 8'h08;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_VT  = 8'h0B;
  localparam byte_t CH_FF  = 8'h0C;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_SO  = 8'h0E;
  localparam byte_t CH_DLE = 8'h10;
  localparam byte_t CH_SUB = 8'h1A;
  localparam byte_t CH_ESC = 8'h1B;
  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_DEL = 8'h7F;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_DEL_BS, S_DEL_SHIFT, S_DEL_SP, S_BSN, S_INS_SHIFT, S_INS_BS,
    S_KSP, S_CR, S_LF, S_EVT, S_TAIL, S_PRD, S_PWR, S_PCP, S_ERD, S_ECK,
    S_FRD, S_FCK, S_RSP, S_RBS, S_RRD, S_RCK, S_RDONE, S_FIN
  } state_t;

endpackage

// ===== sv/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor
// emacs style line editor with a packed history store, one byte at a time
// ----------------------------------------------------------------------------
// usage: received terminal bytes come in on char_in with in_valid/in_ready.
// each byte gives zero or more result beats on the out channel: echo bytes,
// then for a newline the finished line's bytes and a done event; last marks
// the final beat of a byte. cfg_we/cfg_index/cfg_data set the two ignore
// flags; the user must write them only while the block is idle (not enforced).
// in_ready is high only in the idle state; one byte is worked on at a time.
// newline with a non-empty line adds the history push: the older history
// bytes move up by the line length plus terminator, the line bytes are copied
// in and a partial oldest entry at the top is erased.
// ctrl-p/ctrl-n scan the history, reading it through the registered ram,
// before the recall. results pass a one-beat hold stage and an output
// register, so a stalled receiver only holds the sequencer when both fill.
// reset (rst, synchronous) empties the line, clears history valid bits so
// the history reads as zero, and clears the flags and the history position.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF,
  parameter int HIST_LEN = tle_pkg::HIST_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tle_pkg::byte_t    char_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output tle_pkg::byte_t    out_byte,
  output logic [1:0]        event_status,
  output logic [3:0]        line_length,
  output logic              last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data
);

  import tle_pkg::*;

  localparam int LW  = $clog2(LINE_LEN + 1);
  localparam int LIW = $clog2(LINE_LEN);
  localparam int HD  = HIST_LEN + 1;
  localparam int HA  = $clog2(HD);
  localparam int HPW = $clog2(HIST_LEN + 2);

  state_t state, state_next, after, after_next;

  logic ign_esc, ign_lead;

  byte_t          line_mem [LINE_LEN];
  logic [LW-1:0]  count, count_next, cursor, cursor_next;
  logic [LW-1:0]  idx, idx_next, tend, tend_next, rc, rc_next;
  logic [1:0]     sub, sub_next, tkind, tkind_next, evt, evt_next;
  byte_t          ch, ch_next;
  logic [HA-1:0]  hpos, hpos_next, fk, fk_next;
  logic [HPW-1:0] fpos, fpos_next;
  logic           fstart, fstart_next, fup, fup_next;

  // line store access
  logic [LW-1:0]  lra, lwa;
  logic           lwe;
  byte_t          lwd, line_rd;

  // history ram access
  logic           hwe, hv_q;
  logic [HA-1:0]  hwa, hra;
  byte_t          hwd, hrd, hdat;
  logic           hvalid [HD];

  // result path
  logic           emit, flush, out_free, can_go;
  logic [1:0]     e_kind, e_status;
  byte_t          e_byte;
  logic [3:0]     e_len;
  logic           pend_valid;
  logic [1:0]     p_kind, p_status;
  byte_t          p_byte;
  logic [3:0]     p_len;

  logic [LW:0]    idx_p1;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign can_go   = !pend_valid || out_free;
  assign line_rd  = line_mem[lra[LIW-1:0]];
  assign hdat     = hv_q ? hrd : 8'h00;
  assign idx_p1   = {1'b0, idx} + 1'b1;

  tle_ram #(.WIDTH(8), .DEPTH(HD)) u_hist (
    .clk  (clk),
    .we   (hwe),
    .waddr(hwa),
    .wdata(hwd),
    .raddr(hra),
    .rdata(hrd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      after  <= S_FIN;
      count  <= '0;
      cursor <= '0;
      hpos   <= '0;
      ign_esc  <= 1'b0;
      ign_lead <= 1'b0;
      for (int k = 0; k < HD; k++) begin
        hvalid[k] <= 1'b0;
      end
    end else begin
      state  <= state_next;
      after  <= after_next;
      count  <= count_next;
      cursor <= cursor_next;
      hpos   <= hpos_next;
      if (cfg_we) begin
        if (cfg_index == CFG_IGN_ESC) begin
          ign_esc <= cfg_data;
        end else begin
          ign_lead <= cfg_data;
        end
      end
      if (hwe) begin
        hvalid[hwa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    tend   <= tend_next;
    rc     <= rc_next;
    sub    <= sub_next;
    tkind  <= tkind_next;
    evt    <= evt_next;
    ch     <= (state == S_IDLE) ? char_in : ch_next;
    fk     <= fk_next;
    fpos   <= fpos_next;
    fstart <= fstart_next;
    fup    <= fup_next;
    hv_q   <= hvalid[hra];
    if (lwe) begin
      line_mem[lwa[LIW-1:0]] <= lwd;
    end
  end

  always_comb begin
    state_next  = state;
    after_next  = after;
    count_next  = count;
    cursor_next = cursor;
    idx_next    = idx;
    tend_next   = tend;
    rc_next     = rc;
    sub_next    = sub;
    tkind_next  = tkind;
    evt_next    = evt;
    ch_next     = ch;
    hpos_next   = hpos;
    fk_next     = fk;
    fpos_next   = fpos;
    fstart_next = fstart;
    fup_next    = fup;
    lra   = idx;
    lwe   = 1'b0;
    lwa   = idx;
    lwd   = line_rd;
    hwe   = 1'b0;
    hwa   = fpos[HA-1:0];
    hwd   = 8'h00;
    hra   = fpos[HA-1:0];
    emit     = 1'b0;
    flush    = 1'b0;
    e_kind   = KIND_ECHO;
    e_byte   = CH_BS;
    e_status = EV_DONE;
    e_len    = 4'd0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end

      S_DEC: begin
        state_next = S_FIN;
        if (ch == CH_LF) begin
          evt_next   = EV_DONE;
          state_next = S_LF;
        end else if (ch == CH_CR || ch == CH_FF || ch == CH_NUL) begin
          state_next = S_FIN;
        end else if (ch == CH_ESC && ign_esc) begin
          state_next = S_FIN;
        end else if (ign_lead && count == '0 && (ch == CH_SP || ch == CH_TAB)) begin
          state_next = S_FIN;
        end else if (ch == CH_BS || ch == CH_DEL) begin
          if (count != '0 && cursor != '0) begin
            cursor_next = cursor - 1'b1;
            state_next  = S_DEL_BS;
          end
        end else if (ch == CH_ETX) begin
          evt_next   = EV_CANCEL;
          state_next = S_CR;
        end else if (ch == CH_SUB) begin
          evt_next   = EV_EOF;
          state_next = S_CR;
        end else if (ch == CH_DLE) begin
          fk_next     = hpos + 1'b1;
          fup_next    = 1'b1;
          fpos_next   = '0;
          fstart_next = 1'b1;
          state_next  = S_FRD;
        end else if (ch == CH_SO) begin
          if (hpos > HA'(1)) begin
            fk_next     = hpos - 1'b1;
            fup_next    = 1'b0;
            fpos_next   = '0;
            fstart_next = 1'b1;
            state_next  = S_FRD;
          end
        end else if (ch == CH_SOH) begin
          rc_next     = cursor;
          cursor_next = '0;
          state_next  = S_BSN;
        end else if (ch == CH_ENQ) begin
          idx_next    = cursor;
          tend_next   = count;
          cursor_next = count;
          tkind_next  = KIND_ECHO;
          after_next  = S_FIN;
          state_next  = S_TAIL;
        end else if (ch == CH_ACK) begin
          if (cursor < count) begin
            idx_next    = cursor;
            tend_next   = cursor + 1'b1;
            cursor_next = cursor + 1'b1;
            tkind_next  = KIND_ECHO;
            after_next  = S_FIN;
            state_next  = S_TAIL;
          end
        end else if (ch == CH_STX) begin
          if (cursor != '0) begin
            rc_next     = LW'(1);
            cursor_next = cursor - 1'b1;
            state_next  = S_BSN;
          end
        end else if (ch == CH_EOT) begin
          if (cursor < count) begin
            idx_next   = cursor;
            state_next = S_DEL_SHIFT;
          end
        end else if (ch == CH_VT) begin
          if (cursor < count) begin
            rc_next    = count - cursor;
            state_next = S_KSP;
          end
        end else if (count < LW'(LINE_LEN)) begin
          if (ch == CH_TAB) begin
            ch_next = CH_SP;
          end
          idx_next   = count;
          state_next = S_INS_SHIFT;
        end
      end

      S_DEL_BS: begin
        if (can_go) begin
          emit       = 1'b1;
          idx_next   = cursor;
          state_next = S_DEL_SHIFT;
        end
      end

      // close the gap at the cursor, one byte a cycle
      S_DEL_SHIFT: begin
        lra = idx_p1[LW-1:0];
        if (idx_p1 < {1'b0, count}) begin
          lwe      = 1'b1;
          lwa      = idx;
          lwd      = line_rd;
          idx_next = idx_p1[LW-1:0];
        end else begin
          count_next = count - 1'b1;
          idx_next   = cursor;
          tend_next  = count - 1'b1;
          tkind_next = KIND_ECHO;
          after_next = S_DEL_SP;
          state_next = S_TAIL;
        end
      end

      S_DEL_SP: begin
        if (can_go) begin
          emit       = 1'b1;
          e_byte     = CH_SP;
          rc_next    = count + 1'b1 - cursor;
          state_next = S_BSN;
        end
      end

      S_BSN: begin
        if (rc == '0) begin
          state_next = S_FIN;
        end else if (can_go) begin
          emit    = 1'b1;
          rc_next = rc - 1'b1;
        end
      end

      // open a gap at the cursor, one byte a cycle
      S_INS_SHIFT: begin
        lra = idx - 1'b1;
        if (idx > cursor) begin
          lwe      = 1'b1;
          lwa      = idx;
          lwd      = line_rd;
          idx_next = idx - 1'b1;
        end else begin
          lwe         = 1'b1;
          lwa         = cursor;
          lwd         = ch;
          count_next  = count + 1'b1;
          cursor_next = cursor + 1'b1;
          idx_next    = cursor;
          tend_next   = count + 1'b1;
          tkind_next  = KIND_ECHO;
          after_next  = S_INS_BS;
          state_next  = S_TAIL;
        end
      end

      S_INS_BS: begin
        rc_next    = count - cursor;
        state_next = S_BSN;
      end

      S_KSP: begin
        if (rc == '0) begin
          rc_next    = count - cursor;
          count_next = cursor;
          state_next = S_BSN;
        end else if (can_go) begin
          emit    = 1'b1;
          e_byte  = CH_SP;
          rc_next = rc - 1'b1;
        end
      end

      S_CR: begin
        if (can_go) begin
          emit       = 1'b1;
          e_byte     = CH_CR;
          state_next = S_LF;
        end
      end

      S_LF: begin
        if (can_go) begin
          emit   = 1'b1;
          e_byte = CH_LF;
          if (evt == EV_DONE) begin
            idx_next   = '0;
            tend_next  = count;
            tkind_next = KIND_LINE;
            after_next = S_EVT;
            state_next = S_TAIL;
          end else begin
            state_next = S_EVT;
          end
        end
      end

      S_EVT: begin
        if (can_go) begin
          emit     = 1'b1;
          e_kind   = KIND_EVENT;
          e_byte   = 8'h00;
          e_status = evt;
          e_len    = (evt == EV_DONE) ? 4'(count) : 4'd0;
          if (evt == EV_DONE && count != '0) begin
            fpos_next  = HPW'(HIST_LEN);
            state_next = S_PRD;
          end else begin
            count_next  = '0;
            cursor_next = '0;
            if (evt == EV_CANCEL) begin
              hpos_next = '0;
            end
            state_next = S_FIN;
          end
        end
      end

      S_TAIL: begin
        if (idx >= tend) begin
          state_next = after;
        end else if (can_go) begin
          emit     = 1'b1;
          e_kind   = tkind;
          e_byte   = line_rd;
          idx_next = idx + 1'b1;
        end
      end

      // history push: move old entries up by line length plus terminator
      S_PRD: begin
        hra = HA'(fpos - HPW'(count) - 1'b1);
        if (fpos >= HPW'(count) + 1'b1) begin
          state_next = S_PWR;
        end else begin
          idx_next   = '0;
          state_next = S_PCP;
        end
      end

      S_PWR: begin
        hwe        = 1'b1;
        hwa        = fpos[HA-1:0];
        hwd        = hdat;
        fpos_next  = fpos - 1'b1;
        state_next = S_PRD;
      end

      S_PCP: begin
        hwe = 1'b1;
        if (idx < count) begin
          hwa      = HA'(idx);
          hwd      = line_rd;
          idx_next = idx + 1'b1;
        end else begin
          hwa        = HA'(count);
          hwd        = 8'h00;
          fpos_next  = HPW'(HIST_LEN);
          state_next = S_ERD;
        end
      end

      // erase a partial oldest entry from the top down
      S_ERD: begin
        state_next = S_ECK;
      end

      S_ECK: begin
        if (hdat != 8'h00) begin
          hwe        = 1'b1;
          hwd        = 8'h00;
          fpos_next  = fpos - 1'b1;
          state_next = S_ERD;
        end else begin
          count_next  = '0;
          cursor_next = '0;
          hpos_next   = '0;
          state_next  = S_FIN;
        end
      end

      // history lookup: fstart marks the first byte of an entry
      S_FRD: begin
        if (fstart && fpos >= HPW'(HIST_LEN)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_FCK;
        end
      end

      S_FCK: begin
        if (!fstart) begin
          fpos_next = fpos + 1'b1;
          if (hdat == 8'h00) begin
            fstart_next = 1'b1;
          end
          state_next = S_FRD;
        end else if (hdat == 8'h00) begin
          state_next = S_FIN;
        end else if (fk == HA'(1)) begin
          hpos_next  = fup ? hpos + 1'b1 : hpos - 1'b1;
          rc_next    = count - cursor;
          state_next = S_RSP;
        end else begin
          fk_next     = fk - 1'b1;
          fpos_next   = fpos + 1'b1;
          fstart_next = 1'b0;
          state_next  = S_FRD;
        end
      end

      S_RSP: begin
        if (rc == '0) begin
          rc_next    = count;
          sub_next   = 2'd0;
          state_next = S_RBS;
        end else if (can_go) begin
          emit    = 1'b1;
          e_byte  = CH_SP;
          rc_next = rc - 1'b1;
        end
      end

      // rub out the old line as backspace, space, backspace per byte
      S_RBS: begin
        if (rc == '0) begin
          idx_next   = '0;
          state_next = S_RRD;
        end else if (can_go) begin
          emit   = 1'b1;
          e_byte = (sub == 2'd1) ? CH_SP : CH_BS;
          if (sub == 2'd2) begin
            sub_next = 2'd0;
            rc_next  = rc - 1'b1;
          end else begin
            sub_next = sub + 1'b1;
          end
        end
      end

      S_RRD: begin
        if (idx < LW'(LINE_LEN) && fpos <= HPW'(HIST_LEN)) begin
          state_next = S_RCK;
        end else begin
          state_next = S_RDONE;
        end
      end

      S_RCK: begin
        if (hdat != 8'h00) begin
          lwe        = 1'b1;
          lwa        = idx;
          lwd        = hdat;
          idx_next   = idx + 1'b1;
          fpos_next  = fpos + 1'b1;
          state_next = S_RRD;
        end else begin
          state_next = S_RDONE;
        end
      end

      S_RDONE: begin
        count_next  = idx;
        cursor_next = idx;
        tend_next   = idx;
        idx_next    = '0;
        tkind_next  = KIND_ECHO;
        after_next  = S_FIN;
        state_next  = S_TAIL;
      end

      S_FIN: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          flush      = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // one-beat hold stage so the final beat of a byte can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end
      if (flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      p_kind   <= e_kind;
      p_byte   <= e_byte;
      p_status <= e_status;
      p_len    <= e_len;
    end
    if ((emit && pend_valid) || flush) begin
      out_kind     <= p_kind;
      out_byte     <= p_byte;
      event_status <= p_status;
      line_length  <= p_len;
      last         <= flush;
    end
  end

endmodule

// ===== sv/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
